>>> rtl/ghash_pkg.sv
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types, constants and the GF(2^128) multiply for the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghash_pkg;

   localparam int LENGTH_BITS_DEF = 36;
   localparam int BLOCK_BYTES     = 16;
   localparam int COUNT_W         = 5;

   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;

   typedef struct packed {
      logic [63:0]        block_high;
      logic [63:0]        block_low;
      logic [COUNT_W-1:0] byte_count;
      logic               last_block;
   } ghash_req_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_low;
   } ghash_rsp_type;

   typedef struct packed {
      logic [127:0] h;
      logic [127:0] hsq;
      logic         busy;
   } ghash_key_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic [COUNT_W-1:0] count;
      logic [127:0]       blk;
   } ghash_stage_type;

   // GCM bit order: bit 127 of the vector is the x^0 coefficient.
   // Carry-less product, then two folds with x^128 = x^7 + x^2 + x + 1.
   function automatic logic [127:0] gf_mul(input logic [127:0] a, input logic [127:0] b);
      logic [127:0] ra;
      logic [127:0] rb;
      logic [254:0] p;
      logic [126:0] hi;
      logic [134:0] f;
      logic [6:0]   ov;
      logic [127:0] r;
      logic [127:0] res;
      for (int i = 0; i < 128; i++) begin
         ra[i] = a[127-i];
         rb[i] = b[127-i];
      end
      p = '0;
      for (int i = 0; i < 128; i++) begin
         for (int j = 0; j < 128; j++) begin
            p[i+j] = p[i+j] ^ (ra[i] & rb[j]);
         end
      end
      hi = p[254:128];
      f  = {7'b0, p[127:0]} ^ {8'b0, hi} ^ {7'b0, hi, 1'b0} ^ {6'b0, hi, 2'b0}
         ^ {1'b0, hi, 7'b0};
      ov = f[134:128];
      r  = f[127:0] ^ {121'b0, ov} ^ {120'b0, ov, 1'b0} ^ {119'b0, ov, 2'b0}
         ^ {114'b0, ov, 7'b0};
      for (int i = 0; i < 128; i++) begin
         res[i] = r[127-i];
      end
      return res;
   endfunction

endpackage

>>> rtl/ghash_key.sv
// ----------------------------------------------------------------------------
// ghash_key
// Hash subkey registers and the registered square H^2.
// ----------------------------------------------------------------------------
module ghash_key (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [0:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   output ghash_pkg::ghash_key_type key
);

   logic [63:0]  key_high_ff, key_high_in;
   logic [63:0]  key_low_ff, key_low_in;
   logic [127:0] hsq_ff, hsq_in;
   logic         busy_ff, busy_in;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write_en) begin
         case (csr_index)
            ghash_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            ghash_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default: ;
         endcase
      end
      hsq_in  = ghash_pkg::gf_mul({key_high_ff, key_low_ff}, {key_high_ff, key_low_ff});
      busy_in = csr_write_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         hsq_ff      <= '0;
         busy_ff     <= 1'b0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         hsq_ff      <= hsq_in;
         busy_ff     <= busy_in;
      end
   end

   // busy is high during a key write and while H^2 catches up with the new key
   assign key.h    = {key_high_ff, key_low_ff};
   assign key.hsq  = hsq_ff;
   assign key.busy = busy_ff | csr_write_en;

endmodule

>>> rtl/ghash_ingress.sv
// ----------------------------------------------------------------------------
// ghash_ingress
// Input register: count saturation and byte masking of each block.
// ----------------------------------------------------------------------------
module ghash_ingress (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ghash_pkg::ghash_req_type   req_data,
   input  logic                       busy,
   input  logic                       advance,
   output ghash_pkg::ghash_stage_type stage
);

   ghash_pkg::ghash_stage_type stage_ff, stage_in;
   logic [ghash_pkg::COUNT_W-1:0] count_sat;
   logic [127:0]                  blk_raw;
   logic [127:0]                  blk_masked;
   logic                          load;

   assign req_ready = !busy && (!stage_ff.valid || advance);
   assign load      = req_valid && req_ready;

   always_comb begin
      count_sat = (req_data.byte_count > ghash_pkg::COUNT_W'(ghash_pkg::BLOCK_BYTES))
                ? ghash_pkg::COUNT_W'(ghash_pkg::BLOCK_BYTES) : req_data.byte_count;
      blk_raw   = {req_data.block_high, req_data.block_low};
      for (int b = 0; b < ghash_pkg::BLOCK_BYTES; b++) begin
         blk_masked[127-8*b -: 8] = (ghash_pkg::COUNT_W'(b) < count_sat)
                                  ? blk_raw[127-8*b -: 8] : 8'h00;
      end

      stage_in = stage_ff;
      if (load) begin
         stage_in.valid = 1'b1;
         stage_in.last  = req_data.last_block;
         stage_in.count = count_sat;
         stage_in.blk   = blk_masked;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

>>> rtl/ghash_core.sv
// ----------------------------------------------------------------------------
// ghash_core
// Accumulator, byte total, GF multiplies and the result register.
// ----------------------------------------------------------------------------
module ghash_core #(
   parameter int LENGTH_BITS = ghash_pkg::LENGTH_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ghash_pkg::ghash_stage_type stage,
   input  ghash_pkg::ghash_key_type   key,
   output logic                       advance,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ghash_pkg::ghash_rsp_type   rsp_data
);

   logic [127:0]           acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic [127:0]           out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;

   logic                   nonzero;
   logic                   fire;
   logic [127:0]           mul_a;
   logic [127:0]           mul_k;
   logic [127:0]           prod_blk;
   logic [127:0]           prod_len;
   logic [LENGTH_BITS-1:0] total_next;
   logic [63:0]            len_bits;

   // last block with nonzero count: ((A^B)H ^ L)H = (A^B)H^2 ^ LH
   always_comb begin
      advance    = !(stage.valid && stage.last && out_valid_ff && !rsp_ready);
      fire       = stage.valid && advance;
      nonzero    = stage.count != '0;
      mul_a      = nonzero ? (acc_ff ^ stage.blk) : acc_ff;
      mul_k      = (stage.last && nonzero) ? key.hsq : key.h;
      prod_blk   = ghash_pkg::gf_mul(mul_a, mul_k);
      total_next = nonzero ? (total_ff + LENGTH_BITS'(stage.count)) : total_ff;
      len_bits   = 64'({total_next, 3'b000});
      prod_len   = ghash_pkg::gf_mul({64'b0, len_bits}, key.h);

      acc_in       = acc_ff;
      total_in     = total_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (fire) begin
         if (stage.last) begin
            acc_in       = '0;
            total_in     = '0;
            out_in       = prod_blk ^ prod_len;
            out_valid_in = 1'b1;
         end else if (nonzero) begin
            acc_in   = prod_blk;
            total_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_data.digest_high = out_ff[127:64];
   assign rsp_data.digest_low  = out_ff[63:0];

endmodule

>>> rtl/ghash_accumulator.sv
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH over one message stream, empty additional data.
// ----------------------------------------------------------------------------
// Takes one 16-byte block per clock while req_ready is high and registers the
// digest once the last block of a message leaves the input register. Each
// accumulator update is one combinational GF(2^128) multiply by H; the last
// block uses a registered H^2 so the length block folds in the same cycle.
// req_ready is low during a key write and while H^2 is formed. A last block
// waits in the input register only while an earlier digest is not yet taken.
// ----------------------------------------------------------------------------
module ghash_accumulator #(
   parameter int LENGTH_BITS = ghash_pkg::LENGTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ghash_pkg::ghash_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ghash_pkg::ghash_rsp_type rsp_data,
   input  logic                     csr_write_en,
   input  logic [0:0]               csr_index,
   input  logic [63:0]              csr_wdata
);

   ghash_pkg::ghash_key_type   key;
   ghash_pkg::ghash_stage_type stage;
   logic                       advance;

   ghash_key u_key (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .key          (key)
   );

   ghash_ingress u_ingress (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .busy      (key.busy),
      .advance   (advance),
      .stage     (stage)
   );

   ghash_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .key       (key),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> test/ghash_digest_checker.sv
// ----------------------------------------------------------------------------
// ghash_digest_checker
// Watches the GHASH accumulator channels, predicts each digest and compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of H, the running hash and the message byte total. It
// updates them on key writes and accepted items. A last item queues the
// predicted digest, and each accepted digest is checked against the oldest
// entry in that queue.
// ----------------------------------------------------------------------------
module ghash_digest_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  ghash_pkg::ghash_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  ghash_pkg::ghash_rsp_type rsp_data,
   input  logic                     csr_write_en,
   input  logic [0:0]               csr_index,
   input  logic [63:0]              csr_wdata,
   output int                       fail_count,
   output int                       outstanding
);

   logic [127:0]                          hash_key;
   logic [127:0]                          running_hash;
   logic [ghash_pkg::LENGTH_BITS_DEF-1:0] message_bytes;
   ghash_pkg::ghash_rsp_type              expected_digests[$];
   int                                    errors;

   // GCM bit order: x[127] is the x^0 coefficient
   function automatic logic [127:0] ghash_mult(input logic [127:0] x, input logic [127:0] h);
      logic [127:0] prod;
      logic [127:0] v;
      prod = '0;
      v    = h;
      for (int i = 127; i >= 0; i--) begin
         if (x[i]) prod ^= v;
         v = v[0] ? ((v >> 1) ^ {8'he1, 120'b0}) : (v >> 1);
      end
      return prod;
   endfunction

   always @(posedge clock) begin
      int                       cnt;
      logic [127:0]             blk;
      ghash_pkg::ghash_rsp_type want;
      if (reset) begin
         hash_key      = '0;
         running_hash  = '0;
         message_bytes = '0;
         expected_digests.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == ghash_pkg::CSR_KEY_HIGH) hash_key[127:64] = csr_wdata;
            else                                      hash_key[63:0]   = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $error("digest with none expected: %h %h", rsp_data.digest_high,
                      rsp_data.digest_low);
               errors++;
            end else begin
               want = expected_digests.pop_front();
               if (rsp_data.digest_high !== want.digest_high) begin
                  $error("digest_high expected %h actual %h", want.digest_high,
                         rsp_data.digest_high);
                  errors++;
               end
               if (rsp_data.digest_low !== want.digest_low) begin
                  $error("digest_low expected %h actual %h", want.digest_low,
                         rsp_data.digest_low);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            cnt = (req_data.byte_count > ghash_pkg::BLOCK_BYTES)
                ? ghash_pkg::BLOCK_BYTES : int'(req_data.byte_count);
            blk = {req_data.block_high, req_data.block_low};
            if (cnt != 0) begin
               blk &= {128{1'b1}} << (128 - 8 * cnt);
               running_hash  = ghash_mult(running_hash ^ blk, hash_key);
               message_bytes = message_bytes + ghash_pkg::LENGTH_BITS_DEF'(cnt);
            end
            if (req_data.last_block) begin
               // length block: zero AAD bits, then message bits
               running_hash = ghash_mult(running_hash ^ (128'(message_bytes) << 3), hash_key);
               want.digest_high = running_hash[127:64];
               want.digest_low  = running_hash[63:0];
               expected_digests.push_back(want);
               running_hash  = '0;
               message_bytes = '0;
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_digests.size();
   end

endmodule

>>> test/ghash_accumulator_tb.sv
// ----------------------------------------------------------------------------
// ghash_accumulator_tb
// Stimulus and verdict for the GHASH accumulator.
// ----------------------------------------------------------------------------
// Directed blocks, some under a zero key, cover empty messages, every partial
// byte count, oversized counts and zero-count blocks mid-message. Random
// messages follow under three idle mixes with H set to 1, all ones or random.
// Includes a long digest stall and full drains between phases.
// ----------------------------------------------------------------------------
module ghash_accumulator_tb;

   localparam int LIMIT       = 200000;
   localparam int PHASE_ITEMS = 480;
   localparam int SETTLE      = 8;

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   ghash_pkg::ghash_req_type req_data     = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   ghash_pkg::ghash_rsp_type rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [0:0]               csr_index    = ghash_pkg::CSR_KEY_HIGH;
   logic [63:0]              csr_wdata    = '0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_req     = 0;
   int stall_left    = 0;
   int cycle_count   = 0;
   int items_sent    = 0;

   localparam logic [63:0] ONES = {64{1'b1}};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ghash_accumulator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ghash_digest_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (stall_req > 0) begin
         stall_left = stall_req;
         stall_req  = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_block(input logic [63:0] bh, input logic [63:0] bl,
                             input int cnt, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.block_high <= bh;
      req_data.block_low  <= bl;
      req_data.byte_count <= ghash_pkg::COUNT_W'(cnt);
      req_data.last_block <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
      csr_write_en <= 1'b1;
      csr_index    <= ghash_pkg::CSR_KEY_HIGH;
      csr_wdata    <= kh;
      @(posedge clock);
      csr_index    <= ghash_pkg::CSR_KEY_LOW;
      csr_wdata    <= kl;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // mostly well-formed messages; some carry any count and may stay open
   task automatic send_message();
      int  n;
      bit  noisy;
      int  cnt;
      bit  last;
      n     = ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      noisy = ($urandom_range(99) < 15);
      for (int b = 0; b < n; b++) begin
         if (noisy) begin
            cnt  = $urandom_range(31);
            last = ($urandom_range(3) == 0);
         end else begin
            last = (b == n - 1);
            cnt  = last ? $urandom_range(16) : ghash_pkg::BLOCK_BYTES;
         end
         send_block({$urandom, $urandom}, {$urandom, $urandom}, cnt, last);
      end
   endtask

   initial begin
      int phase_end;
      send_idle_pct = 13;
      recv_idle_pct = 48;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // key still zero from reset
      send_block(ONES, ONES, 16, 1'b0);
      send_block(ONES, ONES, 5, 1'b1);
      drain();
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      send_block('0, '0, 0, 1'b1);
      send_block(ONES, ONES, 16, 1'b0);
      send_block('0, '0, 16, 1'b1);
      for (int c = 1; c < 16; c++) send_block(ONES, ONES, c, (c % 4) == 3);
      send_block(ONES, ONES, 17, 1'b0);
      send_block(ONES, ONES, 31, 1'b1);
      send_block(ONES, '0, 16, 1'b0);
      send_block('0, ONES, 0, 1'b0);
      send_block('0, ONES, 8, 1'b1);
      drain();

      // H = 1
      set_key(64'h8000_0000_0000_0000, '0);
      send_idle_pct = 13;
      recv_idle_pct = 48;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end - 250) send_message();
      drain();
      stall_req     = 300;
      repeat (24) send_block({$urandom, $urandom}, {$urandom, $urandom},
                             $urandom_range(16), 1'b1);
      drain();
      while (items_sent < phase_end) send_message();
      drain();

      set_key(ONES, ONES);
      send_idle_pct = 48;
      recv_idle_pct = 13;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end - 200) send_message();
      drain();
      while (items_sent < phase_end) send_message();
      drain();

      set_key({$urandom, $urandom}, {$urandom, $urandom});
      send_idle_pct = 0;
      recv_idle_pct = 0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_message();
      drain();

      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
